### rtl/core/mi3_pkg.sv
package mi3_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // Cross product components need one bit over a full product, the
    // determinant two more over a word times a cross component.
    localparam int PROD_W  = 2 * WORD_BITS;
    localparam int CROSS_W = 2 * WORD_BITS + 1;
    localparam int DPART_W = 2 * WORD_BITS + 2;
    localparam int DET_W   = 3 * WORD_BITS + 3;

    // Quotient bits per lane; the divide runs one bit per stage.
    // Assumes 2*FRAC_BITS >= WORD_BITS so that an oversized quotient saturates.
    localparam int QUO_W  = 2 * FRAC_BITS;
    localparam int SAT_W  = (QUO_W > WORD_BITS) ? QUO_W : WORD_BITS;

    localparam int FRONT_LAT = 5;
    localparam int LANE_LAT  = QUO_W + 3;
    localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT + 1;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [CROSS_W-1:0]   t_cross;
    typedef logic signed [DET_W-1:0]     t_det;

    typedef struct packed {
        t_word m00;
        t_word m01;
        t_word m02;
        t_word m10;
        t_word m11;
        t_word m12;
        t_word m20;
        t_word m21;
        t_word m22;
        logic  last_in;
    } t_mat_in;

    typedef struct packed {
        t_word q00;
        t_word q01;
        t_word q02;
        t_word q10;
        t_word q11;
        t_word q12;
        t_word q20;
        t_word q21;
        t_word q22;
        logic  singular;
        logic  last_out;
    } t_inv_out;

endpackage

### rtl/core/mi3_front.sv
module mi3_front import mi3_pkg::*; (
    input  logic    i_clk,
    input  t_mat_in i_mat,
    output t_cross  o_adj [9],
    output t_det    o_det
);

    t_word e [3][3];

    logic signed [PROD_W-1:0]  r_pa [3][3];
    logic signed [PROD_W-1:0]  r_pb [3][3];
    t_word                     r_row0_1 [3];
    t_cross                    r_c2 [3][3];
    t_word                     r_row0_2 [3];
    t_cross                    r_c3 [3][3];
    logic signed [DPART_W-1:0] r_lo [3];
    logic signed [DPART_W-1:0] r_hi [3];
    t_cross                    r_c4 [3][3];
    t_det                      r_term [3];
    t_cross                    r_c5 [3][3];
    t_det                      r_det;

    assign e[0][0] = i_mat.m00;
    assign e[0][1] = i_mat.m01;
    assign e[0][2] = i_mat.m02;
    assign e[1][0] = i_mat.m10;
    assign e[1][1] = i_mat.m11;
    assign e[1][2] = i_mat.m12;
    assign e[2][0] = i_mat.m20;
    assign e[2][1] = i_mat.m21;
    assign e[2][2] = i_mat.m22;

    // Column j is row (j+1) x row (j+2).
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
                r_pa[j][k] <= e[(j+1)%3][(k+1)%3] * e[(j+2)%3][(k+2)%3];
                r_pb[j][k] <= e[(j+1)%3][(k+2)%3] * e[(j+2)%3][(k+1)%3];
                r_c2[j][k] <= CROSS_W'(r_pa[j][k]) - CROSS_W'(r_pb[j][k]);
                r_c3[j][k] <= r_c2[j][k];
                r_c4[j][k] <= r_c3[j][k];
                r_c5[j][k] <= r_c4[j][k];
            end
            r_row0_1[j] <= e[0][j];
            r_row0_2[j] <= r_row0_1[j];
        end
        // Determinant: split each cross component into a low word and a high part.
        for (int k = 0; k < 3; k++) begin
            r_lo[k] <= DPART_W'(r_row0_2[k]
                       * $signed({1'b0, r_c2[0][k][WORD_BITS-1:0]}));
            r_hi[k] <= DPART_W'(r_row0_2[k] * $signed(r_c2[0][k][CROSS_W-1:WORD_BITS]));
            r_term[k] <= (DET_W'(r_hi[k]) <<< WORD_BITS) + DET_W'(r_lo[k]);
        end
        r_det <= r_term[0] + r_term[1] + r_term[2];
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                o_adj[i*3+j] = r_c5[j][i];
            end
        end
    end

    assign o_det = r_det;

endmodule

### rtl/core/mi3_div_lane.sv
module mi3_div_lane import mi3_pkg::*; (
    input  logic   i_clk,
    input  t_cross i_num,
    input  t_det   i_det,
    output t_word  o_q
);

    logic [CROSS_W-1:0] r_nm;
    logic [DET_W-1:0]   r_dm;
    logic               r_neg_a;

    logic [DET_W-1:0]   r_rem [QUO_W+1];
    logic [DET_W-1:0]   r_den [QUO_W+1];
    logic [QUO_W-1:0]   r_quo [QUO_W+1];
    logic               r_neg [QUO_W+1];
    logic               r_big [QUO_W+1];
    t_word              r_q;

    logic [DET_W:0]     rem2 [QUO_W];
    logic [DET_W:0]     den2 [QUO_W];
    logic               ge   [QUO_W];
    logic [SAT_W-1:0]   val;
    logic [SAT_W-1:0]   lim;
    logic [SAT_W-1:0]   sel;

    always_comb begin
        for (int s = 0; s < QUO_W; s++) begin
            rem2[s] = {r_rem[s], 1'b0};
            den2[s] = {1'b0, r_den[s]};
            ge[s]   = rem2[s] >= den2[s];
        end
    end

    always_comb begin
        val = SAT_W'(r_quo[QUO_W]);
        lim = (SAT_W'(1) << (WORD_BITS - 1)) - SAT_W'(!r_neg[QUO_W]);
        sel = (r_big[QUO_W] || val > lim) ? lim : val;
    end

    always_ff @(posedge i_clk) begin
        // Magnitudes and result sign.
        r_nm    <= i_num[CROSS_W-1] ? CROSS_W'(-i_num) : CROSS_W'(i_num);
        r_dm    <= i_det[DET_W-1] ? DET_W'(-i_det) : DET_W'(i_det);
        r_neg_a <= i_num[CROSS_W-1] ^ i_det[DET_W-1];
        // A numerator not below the divisor gives a quotient past the word.
        r_rem[0] <= DET_W'(r_nm);
        r_den[0] <= r_dm;
        r_quo[0] <= '0;
        r_neg[0] <= r_neg_a;
        r_big[0] <= DET_W'(r_nm) >= r_dm;
        for (int s = 0; s < QUO_W; s++) begin
            r_rem[s+1] <= ge[s] ? DET_W'(rem2[s] - den2[s]) : DET_W'(rem2[s]);
            r_quo[s+1] <= {r_quo[s][QUO_W-2:0], ge[s]};
            r_den[s+1] <= r_den[s];
            r_neg[s+1] <= r_neg[s];
            r_big[s+1] <= r_big[s];
        end
        r_q <= r_neg[QUO_W] ? WORD_BITS'(-sel) : WORD_BITS'(sel);
    end

    assign o_q = r_q;

endmodule

### rtl/core/matrix_inverse_3x3.sv
// 3x3 matrix inverse, adjugate over determinant, signed Q16.16.
// Throughput: one matrix per cycle; busy is never raised.
// The 32 one-bit divide stages in each of the nine lanes set the latency.
// Reset (i_rst_n low, synchronous) drops every matrix in flight; no result follows.
// The receiver cannot stall: each result is shown for one cycle only.
module matrix_inverse_3x3 import mi3_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_mat_in  i_mat,
    output logic     o_done,
    output t_inv_out o_inv
);

    t_cross adj [9];
    t_det   det;
    t_word  lane_q [9];

    // Valid flags follow each beat down the pipe.
    logic [TOTAL_LAT-2:0] r_vld;
    logic                 r_last [TOTAL_LAT-1];
    logic                 r_sing [LANE_LAT];
    logic                 r_done;
    t_inv_out             r_inv;

    // Never hold off a beat: the whole datapath is a free-running pipe.
    assign busy = 1'b0;

    mi3_front u_front (
        .i_clk (i_clk),
        .i_mat (i_mat),
        .o_adj (adj),
        .o_det (det)
    );

    // One divide lane per inverse entry, all sharing the determinant.
    for (genvar g = 0; g < 9; g++) begin : g_lane
        mi3_div_lane u_lane (
            .i_clk (i_clk),
            .i_num (adj[g]),
            .i_det (det),
            .o_q   (lane_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[TOTAL_LAT-3:0], start & ~busy};
            r_done <= r_vld[TOTAL_LAT-2];
        end
    end

    // Side-band flags: last rides the full pipe, singular joins at the lanes.
    always_ff @(posedge i_clk) begin
        r_last[0] <= i_mat.last_in;
        for (int s = 1; s < TOTAL_LAT - 1; s++) begin
            r_last[s] <= r_last[s-1];
        end
        r_sing[0] <= (det == '0);
        for (int s = 1; s < LANE_LAT; s++) begin
            r_sing[s] <= r_sing[s-1];
        end
    end

    // Merge the lanes into one beat; a singular matrix gives all zeros.
    always_ff @(posedge i_clk) begin
        r_inv.q00      <= r_sing[LANE_LAT-1] ? '0 : lane_q[0];
        r_inv.q01      <= r_sing[LANE_LAT-1] ? '0 : lane_q[1];
        r_inv.q02      <= r_sing[LANE_LAT-1] ? '0 : lane_q[2];
        r_inv.q10      <= r_sing[LANE_LAT-1] ? '0 : lane_q[3];
        r_inv.q11      <= r_sing[LANE_LAT-1] ? '0 : lane_q[4];
        r_inv.q12      <= r_sing[LANE_LAT-1] ? '0 : lane_q[5];
        r_inv.q20      <= r_sing[LANE_LAT-1] ? '0 : lane_q[6];
        r_inv.q21      <= r_sing[LANE_LAT-1] ? '0 : lane_q[7];
        r_inv.q22      <= r_sing[LANE_LAT-1] ? '0 : lane_q[8];
        r_inv.singular <= r_sing[LANE_LAT-1];
        r_inv.last_out <= r_last[TOTAL_LAT-2];
    end

    assign o_done = r_done;
    assign o_inv  = r_inv;

endmodule

### rtl/core/mi3_checker.sv
module mi3_checker import mi3_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     start,
    input logic     busy,
    input t_mat_in  i_mat,
    input logic     o_done,
    input t_inv_out o_inv
);

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy) else $error("busy raised");

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, TOTAL_LAT)) else $error("result without a beat");

    a_last_carried: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_inv.last_out == $past(i_mat.last_in, TOTAL_LAT)))
        else $error("last flag lost");

    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_inv.singular) |-> (o_inv.q00 == '0 && o_inv.q11 == '0
        && o_inv.q22 == '0 && o_inv.q01 == '0 && o_inv.q12 == '0))
        else $error("singular result not zero");

endmodule

bind matrix_inverse_3x3 mi3_checker u_mi3_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_mat   (i_mat),
    .o_done  (o_done),
    .o_inv   (o_inv)
);

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import mi3_pkg::*;

    typedef logic signed [127:0] t_wide;

    logic     i_clk;
    logic     i_rst_n;
    logic     start;
    logic     busy;
    t_mat_in  i_mat;
    logic     o_done;
    t_inv_out o_inv;

    int unsigned mismatches = 0;

    // Q16.16 one and the saturation bounds of a result word
    localparam t_word ONE_Q = 32'sh0001_0000;
    localparam t_wide SAT_HI = 128'sh7FFF_FFFF;
    localparam t_wide SAT_LO = -128'sh8000_0000;

    matrix_inverse_3x3 uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_mat   (i_mat),
        .o_done  (o_done),
        .o_inv   (o_inv)
    );

    // Print one line per mismatch and count it
    task automatic report(input string what);
        $display("[%0t] %s", $time, what);
        mismatches++;
    endtask

    // Holds the inverses still owed by the pipeline, oldest first
    class inverse_board;
        t_inv_out owed[$];

        // a*b - c*d at full width
        static function t_wide cofactor(t_word a, t_word b, t_word c, t_word d);
            t_wide wa, wb, wc, wd;
            wa = a; wb = b; wc = c; wd = d;
            return wa * wb - wc * wd;
        endfunction

        // Scale a cross component by 2^32 over the determinant, truncate, clamp
        static function t_word scale_div(t_wide c, t_wide det);
            t_wide q;
            q = (c <<< (2 * FRAC_BITS)) / det;
            if (q > SAT_HI) q = SAT_HI;
            if (q < SAT_LO) q = SAT_LO;
            return q[WORD_BITS-1:0];
        endfunction

        static function t_inv_out invert(t_mat_in m);
            t_wide    col[3][3];
            t_wide    det, w0, w1, w2;
            t_inv_out r;
            // columns: r1 x r2, r2 x r0, r0 x r1
            col[0][0] = cofactor(m.m11, m.m22, m.m12, m.m21);
            col[0][1] = cofactor(m.m12, m.m20, m.m10, m.m22);
            col[0][2] = cofactor(m.m10, m.m21, m.m11, m.m20);
            col[1][0] = cofactor(m.m21, m.m02, m.m22, m.m01);
            col[1][1] = cofactor(m.m22, m.m00, m.m20, m.m02);
            col[1][2] = cofactor(m.m20, m.m01, m.m21, m.m00);
            col[2][0] = cofactor(m.m01, m.m12, m.m02, m.m11);
            col[2][1] = cofactor(m.m02, m.m10, m.m00, m.m12);
            col[2][2] = cofactor(m.m00, m.m11, m.m01, m.m10);
            w0 = m.m00; w1 = m.m01; w2 = m.m02;
            det = w0 * col[0][0] + w1 * col[0][1] + w2 * col[0][2];
            r = '0;
            r.last_out = m.last_in;
            if (det == 0) begin
                r.singular = 1'b1;
                return r;
            end
            // entry (i,j) comes from column j, component i
            r.q00 = scale_div(col[0][0], det);
            r.q01 = scale_div(col[1][0], det);
            r.q02 = scale_div(col[2][0], det);
            r.q10 = scale_div(col[0][1], det);
            r.q11 = scale_div(col[1][1], det);
            r.q12 = scale_div(col[2][1], det);
            r.q20 = scale_div(col[0][2], det);
            r.q21 = scale_div(col[1][2], det);
            r.q22 = scale_div(col[2][2], det);
            return r;
        endfunction

        function void note_matrix(t_mat_in m);
            owed.push_back(invert(m));
        endfunction

        task check_inverse(t_inv_out got);
            t_inv_out exp_r;
            if (owed.size() == 0) begin
                report("inverse beat with none outstanding");
                return;
            end
            exp_r = owed.pop_front();
            if (got.q00 !== exp_r.q00) report($sformatf("q00 %h want %h", got.q00, exp_r.q00));
            if (got.q01 !== exp_r.q01) report($sformatf("q01 %h want %h", got.q01, exp_r.q01));
            if (got.q02 !== exp_r.q02) report($sformatf("q02 %h want %h", got.q02, exp_r.q02));
            if (got.q10 !== exp_r.q10) report($sformatf("q10 %h want %h", got.q10, exp_r.q10));
            if (got.q11 !== exp_r.q11) report($sformatf("q11 %h want %h", got.q11, exp_r.q11));
            if (got.q12 !== exp_r.q12) report($sformatf("q12 %h want %h", got.q12, exp_r.q12));
            if (got.q20 !== exp_r.q20) report($sformatf("q20 %h want %h", got.q20, exp_r.q20));
            if (got.q21 !== exp_r.q21) report($sformatf("q21 %h want %h", got.q21, exp_r.q21));
            if (got.q22 !== exp_r.q22) report($sformatf("q22 %h want %h", got.q22, exp_r.q22));
            if (got.singular !== exp_r.singular)
                report($sformatf("singular %b want %b", got.singular, exp_r.singular));
            if (got.last_out !== exp_r.last_out)
                report($sformatf("last_out %b want %b", got.last_out, exp_r.last_out));
        endtask
    endclass

    inverse_board board = new();

    // 4 ns clock
    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // Sample both sides at the edge: a start beat is noted, a done beat checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) board.note_matrix(i_mat);
            if (o_done) board.check_inverse(o_inv);
        end
    end

    // Burst state of the sender: beats left in this burst
    int burst_left = 0;

    // Hold start and the matrix until the block takes the beat; idle between most bursts
    task automatic send_matrix(input t_mat_in m);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                i_mat <= t_mat_in'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                    $urandom, $urandom, $urandom, $urandom, 1'b0});
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        i_mat <= m;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic t_word rnd_word(int kind);
        case (kind)
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            2:       return $signed($urandom_range(0, 32'h0000_0400)) - 32'sh0000_0200;
            default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic t_mat_in make_mat(t_word a, t_word b, t_word c, t_word d,
                                         t_word e, t_word f, t_word g, t_word h,
                                         t_word k, logic lst);
        t_mat_in m;
        m.m00 = a; m.m01 = b; m.m02 = c;
        m.m10 = d; m.m11 = e; m.m12 = f;
        m.m20 = g; m.m21 = h; m.m22 = k;
        m.last_in = lst;
        return m;
    endfunction

    localparam t_word W_MAX = 32'sh7FFF_FFFF;
    localparam t_word W_MIN = 32'sh8000_0000;

    initial begin
        t_mat_in m;
        int      kind;
        int      sel;
        t_word   s;
        start   <= 1'b0;
        i_mat   <= '0;
        i_rst_n <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: identity, scaled diagonals, zero and rank-deficient matrices,
        // extreme entries, saturating and sign-flipping inverses
        send_matrix(make_mat(ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q, 1'b0));
        send_matrix(make_mat(ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q, 1'b1));
        send_matrix(make_mat(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        send_matrix(make_mat(ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 2 * ONE_Q, 4 * ONE_Q,
                             6 * ONE_Q, 7, 8, 9, 1'b0));
        send_matrix(make_mat(1, 0, 0, 0, 1, 0, 0, 0, 1, 1'b0));
        send_matrix(make_mat(-1, 0, 0, 0, -1, 0, 0, 0, -1, 1'b1));
        send_matrix(make_mat(W_MAX, 0, 0, 0, W_MAX, 0, 0, 0, W_MAX, 1'b0));
        send_matrix(make_mat(W_MIN, 0, 0, 0, W_MIN, 0, 0, 0, W_MIN, 1'b0));
        send_matrix(make_mat(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN,
                             W_MIN, W_MIN, W_MIN, 1'b1));
        send_matrix(make_mat(W_MAX, W_MIN, 0, W_MIN, W_MAX, 0, 0, 0, ONE_Q, 1'b0));
        send_matrix(make_mat(W_MIN, W_MAX, W_MAX, W_MAX, W_MIN, W_MAX,
                             W_MAX, W_MAX, W_MIN, 1'b0));
        send_matrix(make_mat(0, ONE_Q, 0, ONE_Q, 0, 0, 0, 0, ONE_Q, 1'b0));
        send_matrix(make_mat(0, 0, -ONE_Q, 0, 2 * ONE_Q, 0, ONE_Q / 2, 0, 0, 1'b1));
        send_matrix(make_mat(-1, -1, -1, -1, -1, -1, -1, -1, -1, 1'b0));
        send_matrix(make_mat(3 * ONE_Q, 0, 0, 0, 3 * ONE_Q, 0, 0, 0, 3 * ONE_Q, 1'b0));
        send_matrix(make_mat(2, 1, 0, 1, 2, 1, 0, 1, 2, 1'b1));

        // Random: mostly moderate values so inverses land in range, with
        // full-width words, perturbed identities and rank-deficient cases mixed in
        repeat (840) begin
            sel = $urandom_range(0, 9);
            kind = $urandom_range(0, 3);
            m = make_mat(rnd_word(kind), rnd_word(kind), rnd_word(kind),
                         rnd_word(kind), rnd_word(kind), rnd_word(kind),
                         rnd_word(kind), rnd_word(kind), rnd_word(kind), 1'($urandom));
            if (sel == 0) begin
                // row 2 a copy of row 0 scaled: singular
                s = $signed($urandom_range(0, 6)) - 3;
                m.m20 = m.m00 * s; m.m21 = m.m01 * s; m.m22 = m.m02 * s;
            end else if (sel == 1) begin
                // zero a row or column
                if ($urandom_range(0, 1)) begin
                    m.m10 = 0; m.m11 = 0; m.m12 = 0;
                end else begin
                    m.m02 = 0; m.m12 = 0; m.m22 = 0;
                end
            end else if (sel == 2) begin
                // identity plus a small perturbation
                m.m00 = ONE_Q + rnd_word(2); m.m11 = ONE_Q + rnd_word(2);
                m.m22 = ONE_Q + rnd_word(2);
            end
            send_matrix(m);
        end
        start <= 1'b0;

        // Drain: wait for every owed inverse, then a pipeline's worth more
        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (TOTAL_LAT + 10) @(posedge i_clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end
endmodule
